@@ hw/rtl/ps2_mouse_packet_tracker_assert.svh @@
// assertion macros for the mouse packet tracker
// clocked on clk_i; the checked form is switched off by ASSERT_OFF
`ifndef PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH
`define PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH

`ifndef ASSERT_OFF

// checked while out of reset
`define PS2MT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define PS2MT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define PS2MT_ASSERT(lbl, prop, msg)
`define PS2MT_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ hw/rtl/ps2mt_pkg.sv @@
`default_nettype none

package ps2mt_pkg;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned PosW    = 16;
  localparam int unsigned BtnW    = 3;
  localparam int unsigned DeltaW  = 9;

  // default coordinate width
  localparam int unsigned CoordWidthDef = 16;

  // bit positions in the head byte
  localparam int unsigned SyncBit  = 3;
  localparam int unsigned XSignBit = 4;
  localparam int unsigned YSignBit = 5;

  // reset values
  localparam int unsigned ResetX    = 400;
  localparam int unsigned ResetY    = 300;
  localparam int unsigned ResetMaxX = 799;
  localparam int unsigned ResetMaxY = 599;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgMaxX = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxY = 2'd1;

  // a completed packet, handed from assembler to tracker
  typedef struct packed {
    logic             done;
    logic [ByteW-1:0] head;
    logic [ByteW-1:0] second;
    logic [ByteW-1:0] third;
  } pkt_t;

endpackage

`default_nettype wire

@@ hw/rtl/ps2mt_assembler.sv @@
`default_nettype none

module ps2mt_assembler import ps2mt_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [ByteW-1:0] data_byte_i,
  output pkt_t                  pkt_o
);

  typedef enum logic [1:0] {
    IdxHead,
    IdxSecond,
    IdxThird
  } idx_e;

  idx_e             idx_q;
  logic [ByteW-1:0] head_q;
  logic [ByteW-1:0] second_q;

  // byte position, head and second byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= IdxHead;
      head_q   <= '0;
      second_q <= '0;
    end else if (accept_i) begin
      unique case (idx_q)
        IdxHead: begin
          // drop bytes without the sync bit while hunting for a head
          if (data_byte_i[SyncBit]) begin
            head_q <= data_byte_i;
            idx_q  <= IdxSecond;
          end
        end
        IdxSecond: begin
          second_q <= data_byte_i;
          idx_q    <= IdxThird;
        end
        default: begin
          idx_q <= IdxHead;
        end
      endcase
    end
  end

  // packet completes on the third byte
  always_comb begin
    pkt_o.done   = accept_i && (idx_q != IdxHead) && (idx_q != IdxSecond);
    pkt_o.head   = head_q;
    pkt_o.second = second_q;
    pkt_o.third  = data_byte_i;
  end

endmodule

`default_nettype wire

@@ hw/rtl/ps2mt_tracker.sv @@
`default_nettype none

module ps2mt_tracker import ps2mt_pkg::*; #(
  parameter int unsigned CoordWidth = CoordWidthDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [CfgW-1:0]          cfg_wdata_i,
  input  wire pkt_t                     pkt_i,
  input  wire logic                     out_ready_i,
  output logic                          out_valid_o,
  output logic [PosW-1:0]               pos_x_o,
  output logic [PosW-1:0]               pos_y_o,
  output logic [BtnW-1:0]               button_bits_o,
  output logic signed [DeltaW-1:0]      delta_x_o,
  output logic signed [DeltaW-1:0]      delta_y_o
);

  localparam int unsigned SumW = ((CoordWidth > CfgW) ? CoordWidth : CfgW) + 2;
  localparam logic [SumW-1:0] CoordMask =
    {{(SumW-CoordWidth){1'b0}}, {CoordWidth{1'b1}}};

  logic [CfgW-1:0]          max_x_q, max_y_q;
  logic [CoordWidth-1:0]    cur_x_q, cur_y_q;
  logic [CoordWidth-1:0]    cur_x_d, cur_y_d;
  logic                     out_valid_q;
  logic [BtnW-1:0]          btn_q;
  logic signed [DeltaW-1:0] dx_q, dy_q;

  logic signed [DeltaW-1:0] dx, dy;
  logic signed [SumW-1:0]   sum_x, sum_y;
  logic [SumW-1:0]          lim_x, lim_y;

  function automatic logic [CoordWidth-1:0] clamp(input logic signed [SumW-1:0] v,
                                                  input logic [SumW-1:0] hi);
    logic [CoordWidth-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if ($unsigned(v) > hi) begin
      r = hi[CoordWidth-1:0];
    end else begin
      r = v[CoordWidth-1:0];
    end
    return r;
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_x_q <= CfgW'(ResetMaxX);
      max_y_q <= CfgW'(ResetMaxY);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMaxX: max_x_q <= cfg_wdata_i;
        CfgMaxY: max_y_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sign-extended deltas from the head byte sign bits
  assign dx = $signed({pkt_i.head[XSignBit], pkt_i.second});
  assign dy = $signed({pkt_i.head[YSignBit], pkt_i.third});

  // limit saturated to the coordinate range
  assign lim_x = (SumW'(max_x_q) > CoordMask) ? CoordMask : SumW'(max_x_q);
  assign lim_y = (SumW'(max_y_q) > CoordMask) ? CoordMask : SumW'(max_y_q);

  // add, subtract and clamp
  assign sum_x = $signed({{(SumW-CoordWidth){1'b0}}, cur_x_q}) + SumW'(dx);
  assign sum_y = $signed({{(SumW-CoordWidth){1'b0}}, cur_y_q}) - SumW'(dy);
  assign cur_x_d = clamp(sum_x, lim_x);
  assign cur_y_d = clamp(sum_y, lim_y);

  // position and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= CoordWidth'(ResetX);
      cur_y_q     <= CoordWidth'(ResetY);
      out_valid_q <= 1'b0;
    end else begin
      if (pkt_i.done) begin
        cur_x_q     <= cur_x_d;
        cur_y_q     <= cur_y_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pkt_i.done) begin
      btn_q <= pkt_i.head[BtnW-1:0];
      dx_q  <= dx;
      dy_q  <= dy;
    end
  end

  // position holds while a result waits, since input is stalled then
  assign out_valid_o   = out_valid_q;
  assign pos_x_o       = PosW'(cur_x_q);
  assign pos_y_o       = PosW'(cur_y_q);
  assign button_bits_o = btn_q;
  assign delta_x_o     = dx_q;
  assign delta_y_o     = dy_q;

endmodule

`default_nettype wire

@@ hw/rtl/ps2_mouse_packet_tracker.sv @@
// result: registered, valid in the cycle after a packet's third byte transfer
// throughput: one byte per cycle; input stalls only while a result waits
// reset: asynchronous, active low; position 400/300, limits 799/599,
// packet hunt restarts at a head byte
`default_nettype none

`include "ps2_mouse_packet_tracker_assert.svh"

module ps2_mouse_packet_tracker import ps2mt_pkg::*; #(
  parameter int unsigned CoordWidth = CoordWidthDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [CfgW-1:0]      cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [ByteW-1:0]     data_byte_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [PosW-1:0]           pos_x_o,
  output logic [PosW-1:0]           pos_y_o,
  output logic [BtnW-1:0]           button_bits_o,
  output logic signed [DeltaW-1:0]  delta_x_o,
  output logic signed [DeltaW-1:0]  delta_y_o
);

  logic accept;
  pkt_t pkt;

  // take a byte unless a result is stuck in the output register
  assign in_ready_o = !out_valid_o || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  ps2mt_assembler u_assembler (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .pkt_o       (pkt)
  );

  ps2mt_tracker #(
    .CoordWidth (CoordWidth)
  ) u_tracker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pkt_i         (pkt),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .button_bits_o (button_bits_o),
    .delta_x_o     (delta_x_o),
    .delta_y_o     (delta_y_o)
  );

  // a result appears only after a completed packet
  `PS2MT_ASSERT(a_rise_after_pkt, $rose(out_valid_o) |-> $past(pkt.done), "result without packet")
  // a completed packet always yields a result
  `PS2MT_ASSERT(a_pkt_gives_result, pkt.done |=> out_valid_o, "packet lost")
  // every completed packet started on a byte with the sync bit
  `PS2MT_ASSERT(a_head_synced, pkt.done |-> pkt.head[SyncBit], "packet head without sync bit")

endmodule

`default_nettype wire

@@ sim/tb_ps2_mouse_packet_tracker.sv @@
`timescale 1ns / 100ps

module tb_ps2_mouse_packet_tracker;
  import ps2mt_pkg::*;

  localparam int unsigned RunLimit  = 200000;
  localparam int unsigned CoordMax  = (1 << CoordWidthDef) - 1;
  localparam int          DeltaSpan = 256;
  localparam int unsigned DrainWait = 4;

  // indexes that decode to no register
  localparam logic [CfgIdxW-1:0] CfgSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpare3 = 2'd3;

  typedef enum logic [1:0] {HuntHead, GotHead, GotSecond} pkt_phase_e;

  typedef struct {
    logic [PosW-1:0]          x;
    logic [PosW-1:0]          y;
    logic [BtnW-1:0]          buttons;
    logic signed [DeltaW-1:0] dx;
    logic signed [DeltaW-1:0] dy;
  } pointer_report_t;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]       cfg_idx_i     = '0;
  logic [CfgW-1:0]          cfg_wdata_i   = '0;
  logic                     in_valid_i    = 1'b0;
  logic                     in_ready_o;
  logic [ByteW-1:0]         data_byte_i   = '0;
  logic                     out_valid_o;
  logic                     out_ready_i   = 1'b0;
  logic [PosW-1:0]          pos_x_o;
  logic [PosW-1:0]          pos_y_o;
  logic [BtnW-1:0]          button_bits_o;
  logic signed [DeltaW-1:0] delta_x_o;
  logic signed [DeltaW-1:0] delta_y_o;

  // tracker state as predicted
  pkt_phase_e       pkt_phase  = HuntHead;
  logic [ByteW-1:0] pkt_head   = '0;
  logic [ByteW-1:0] pkt_second = '0;
  int               track_x    = ResetX;
  int               track_y    = ResetY;
  int unsigned      lim_x      = ResetMaxX;
  int unsigned      lim_y      = ResetMaxY;

  pointer_report_t  pending_reports[$];
  int unsigned      mismatches      = 0;
  int unsigned      cycle_cnt       = 0;
  bit               idling_on       = 1'b1;
  int unsigned      hold_off_cycles = 0;

  ps2_mouse_packet_tracker u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .button_bits_o (button_bits_o),
    .delta_x_o     (delta_x_o),
    .delta_y_o     (delta_y_o)
  );

  always #5 clk_i = ~clk_i;

  // clamp to 0 .. limit, limit saturated to the coordinate range
  function automatic int clamp_coord(int v, int unsigned limit);
    int hi;
    hi = (limit > CoordMax) ? int'(CoordMax) : int'(limit);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // packet assembly and pointer update for one transferred byte
  function automatic void track_byte(logic [ByteW-1:0] b);
    int dx;
    int dy;
    pointer_report_t rep;
    case (pkt_phase)
      HuntHead: begin
        if (b[SyncBit]) begin
          pkt_head  = b;
          pkt_phase = GotHead;
        end
      end
      GotHead: begin
        pkt_second = b;
        pkt_phase  = GotSecond;
      end
      default: begin
        pkt_phase = HuntHead;
        dx = int'(pkt_second);
        dy = int'(b);
        if (pkt_head[XSignBit]) dx -= DeltaSpan;
        if (pkt_head[YSignBit]) dy -= DeltaSpan;
        track_x = clamp_coord(track_x + dx, lim_x);
        track_y = clamp_coord(track_y - dy, lim_y);
        rep.x       = track_x[PosW-1:0];
        rep.y       = track_y[PosW-1:0];
        rep.buttons = pkt_head[BtnW-1:0];
        rep.dx      = dx[DeltaW-1:0];
        rep.dy      = dy[DeltaW-1:0];
        pending_reports.push_back(rep);
      end
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin : check_reports
    pointer_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none actual x=%0d y=%0d", $time,
                 pos_x_o, pos_y_o);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("pos_x", int'(want.x), int'(pos_x_o));
        check_field("pos_y", int'(want.y), int'(pos_y_o));
        check_field("button_bits", int'(want.buttons), int'(button_bits_o));
        check_field("delta_x", int'(want.dx), int'(delta_x_o));
        check_field("delta_y", int'(want.dy), int'(delta_y_o));
      end
    end
  end

  // result side: long hold-off on request, random stall bursts while idling is on
  initial begin : report_sink
    @(posedge clk_i);
    forever begin
      if (hold_off_cycles != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // run limit
  initial begin : watchdog
    while (cycle_cnt < RunLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb_ps2_mouse_packet_tracker NOT OK");
    $finish;
  end

  // offer one byte, optionally after an idle burst, and wait for its transfer
  task automatic send_byte(logic [ByteW-1:0] b);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    track_byte(b);
  endtask

  task automatic send_packet(logic [ByteW-1:0] head, logic [ByteW-1:0] second,
                             logic [ByteW-1:0] third);
    send_byte(head);
    send_byte(second);
    send_byte(third);
  endtask

  task automatic send_random_packet();
    logic [ByteW-1:0] head;
    head = ByteW'($urandom_range(0, 255));
    head[SyncBit] = 1'b1;
    send_packet(head, ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)));
  endtask

  // stop offering and wait until every predicted report has arrived
  task automatic drain_reports();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CfgMaxX) lim_x = 32'(value);
    else if (idx == CfgMaxY) lim_y = 32'(value);
  endtask

  function automatic logic [CfgW-1:0] pick_limit();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return CfgW'($urandom_range(1, 63));
      3:       return CfgW'($urandom_range(64, 1023));
      default: return CfgW'($urandom_range(0, 65535));
    endcase
  endfunction

  // reset limits: sync hunt, delta extremes, sign bits, buttons, clamping
  task automatic test_reset_limits();
    idling_on = 1'b1;
    send_byte(8'h00);
    send_byte(8'hf7);
    send_packet(8'h08, 8'h00, 8'h00);
    send_packet(8'h09, 8'hff, 8'h00);
    send_packet(8'h0a, 8'hff, 8'h00);
    send_packet(8'h3c, 8'h00, 8'h00);
    send_packet(8'h2f, 8'h00, 8'h00);
    send_packet(8'h1b, 8'h00, 8'hff);
    send_packet(8'hcd, 8'h80, 8'h7f);
    send_packet(8'h1e, 8'h00, 8'h01);
    drain_reports();
  endtask

  // both registers at their extremes, ignored indexes, then limits lowered again
  task automatic test_limit_registers();
    write_reg(CfgMaxX, 16'h0000);
    write_reg(CfgMaxY, 16'h0000);
    send_packet(8'h08, 8'h05, 8'h05);
    send_packet(8'h38, 8'h80, 8'h80);
    drain_reports();
    write_reg(CfgSpare2, 16'h0005);
    write_reg(CfgSpare3, 16'h00ff);
    send_packet(8'h08, 8'h7f, 8'h00);
    drain_reports();
    write_reg(CfgMaxX, 16'hffff);
    write_reg(CfgMaxY, 16'hffff);
    repeat (4) send_packet(8'h28, 8'hff, 8'h01);
    drain_reports();
    write_reg(CfgMaxX, 16'd100);
    write_reg(CfgMaxY, 16'd50);
    send_packet(8'h08, 8'h00, 8'h00);
    send_packet(8'h3f, 8'hf0, 8'h10);
    drain_reports();
  endtask

  // mostly well-formed packets with random content, some stray bytes
  task automatic test_random_traffic();
    int unsigned sent;
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(CfgMaxX, pick_limit());
      write_reg(CfgMaxY, pick_limit());
      write_reg(CfgIdxW'($urandom_range(2, 3)), CfgW'($urandom_range(0, 65535)));
      idling_on = ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < 105) begin
        if ($urandom_range(0, 4) == 0) begin
          send_byte(ByteW'($urandom_range(0, 255)));
          sent += 1;
        end else begin
          send_random_packet();
          sent += 3;
        end
      end
      drain_reports();
    end
  endtask

  // receiver holds off while packets keep coming, so the input stalls
  task automatic test_output_hold_off();
    idling_on = 1'b0;
    write_reg(CfgMaxX, CfgW'(ResetMaxX));
    write_reg(CfgMaxY, CfgW'(ResetMaxY));
    hold_off_cycles = 120;
    repeat (10) send_random_packet();
    drain_reports();
  endtask

  // closing stretch with no idling on either side
  task automatic test_back_to_back();
    idling_on = 1'b0;
    repeat (20) send_random_packet();
    drain_reports();
  endtask

  initial begin : main_sequence
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_limits();
    test_limit_registers();
    test_random_traffic();
    test_output_hold_off();
    test_back_to_back();
    if (mismatches == 0) begin
      $display("tb_ps2_mouse_packet_tracker OK");
    end else begin
      $display("tb_ps2_mouse_packet_tracker NOT OK");
    end
    $finish;
  end

endmodule
